FILE: rtl/hpid_pkg.sv
// hpid_pkg: widths, constants, register indexes and helpers for the heading pid
// turn controller. No dependencies.
package hpid_pkg;

  localparam int unsigned GAIN_FRAC_BITS = 8;

  localparam int unsigned HeadW   = 13;  // heading and angle registers
  localparam int unsigned PowerW  = 7;   // max power register
  localparam int unsigned GainW   = 16;  // Q8.8 gains
  localparam int unsigned ErrW    = 14;  // wrapped error
  localparam int unsigned DerivW  = 15;  // error minus previous error
  localparam int unsigned SumW    = 32;  // integral
  localparam int unsigned OutW    = 8;   // motor drive
  localparam int unsigned WideW   = 16;  // raw difference plus or minus a turn
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned PProdW = GainW + 1 + WideW;
  localparam int unsigned IProdW = GainW + 1 + SumW;
  localparam int unsigned DProdW = GainW + 1 + DerivW;
  localparam int unsigned AccW   = IProdW + 2;
  localparam int unsigned ShW    = AccW - GAIN_FRAC_BITS;

  localparam logic signed [WideW-1:0] FULL_TURN = WideW'(5760);

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_HEADING = 3'd0,
    REG_MAX_POWER      = 3'd1,
    REG_STOP_THRESHOLD = 3'd2,
    REG_GAIN_P         = 3'd3,
    REG_GAIN_I         = 3'd4,
    REG_GAIN_D         = 3'd5,
    REG_INTEGRAL_ZONE  = 3'd6,
    REG_UNUSED         = 3'd7
  } cfg_reg_e;

  function automatic logic [WideW-1:0] mag_f(input logic signed [WideW-1:0] v);
    mag_f = v[WideW-1] ? WideW'(-v) : WideW'(v);
  endfunction

endpackage

FILE: rtl/heading_pid_turn_controller_top.sv
// heading_pid_turn_controller_top: heading pid step with angle wrap, integral zone,
// saturating integral and clamped differential motor drive. Depends on hpid_pkg.

// One heading sample in, one result out, and a new sample is taken every clock
// while the output is not stalled. The input register loads at the accepting edge,
// then the error and integral stage, the gain multiply stage and the
// sum/shift/clamp into the output register follow in turn. The integral and
// previous error close their loop within the error stage, so consecutive
// samples see each other's state. When the output is held by the consumer, the
// whole pipeline holds and in_ready_o drops in the same cycle. Configuration
// writes take effect at once and are meant for times when no transaction is
// in flight.
module heading_pid_turn_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hpid_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hpid_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hpid_pkg::HeadW-1:0]    measured_heading_i,
  input  logic                          start_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [hpid_pkg::OutW-1:0] left_power_o,
  output logic signed [hpid_pkg::OutW-1:0] right_power_o,
  output logic signed [hpid_pkg::ErrW-1:0] heading_error_o,
  output logic                          done_res_o
);
  import hpid_pkg::*;

  // configuration registers
  logic [HeadW-1:0]  target_q, thresh_q, zone_q;
  logic [PowerW-1:0] max_power_q;
  logic [GainW-1:0]  gain_p_q, gain_i_q, gain_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      max_power_q <= PowerW'(127);
      thresh_q    <= HeadW'(16);
      gain_p_q    <= GainW'(256);
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      zone_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TARGET_HEADING: target_q    <= cfg_data_i[HeadW-1:0];
        REG_MAX_POWER:      max_power_q <= cfg_data_i[PowerW-1:0];
        REG_STOP_THRESHOLD: thresh_q    <= cfg_data_i[HeadW-1:0];
        REG_GAIN_P:         gain_p_q    <= cfg_data_i[GainW-1:0];
        REG_GAIN_I:         gain_i_q    <= cfg_data_i[GainW-1:0];
        REG_GAIN_D:         gain_d_q    <= cfg_data_i[GainW-1:0];
        REG_INTEGRAL_ZONE:  zone_q      <= cfg_data_i[HeadW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances together unless the output is stalled
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // stage 0: input register
  logic             v0_q, start0_q;
  logic [HeadW-1:0] meas0_q;

  // stage 1: error, integral, derivative
  // the tie at half a turn takes the plus-turn form, so the loop keeps the full error
  logic                     v1_q, done1_q;
  logic signed [WideW-1:0]  err1_q;
  logic signed [SumW-1:0]   sum1_q;
  logic signed [DerivW-1:0] deriv1_q;

  // loop state
  logic signed [WideW-1:0] prev_err_q;
  logic signed [SumW-1:0]  sum_q;

  // stage 2: products
  logic                     v2_q, done2_q;
  logic signed [ErrW-1:0]   err2_q;
  logic signed [PProdW-1:0] p_prod_q;
  logic signed [IProdW-1:0] i_prod_q;
  logic signed [DProdW-1:0] d_prod_q;

  // stage 3: output register
  logic                   out_valid_q, done_q;
  logic signed [OutW-1:0] left_q;
  logic signed [ErrW-1:0] err_out_q;

  // error selection among plain, minus a turn and plus a turn
  logic signed [WideW-1:0] plain, minus_t, plus_t, err_w;
  logic [WideW-1:0]        m_plain, m_minus, m_plus, m_err;
  logic signed [WideW-1:0] prev_base;
  logic signed [SumW-1:0]  sum_base, sum_d;
  logic signed [SumW:0]    sum_add;
  logic signed [DerivW-1:0] deriv_d;
  logic                    done_d;

  always_comb begin
    plain   = $signed({{(WideW-HeadW){1'b0}}, target_q})
            - $signed({{(WideW-HeadW){1'b0}}, meas0_q});
    minus_t = plain - FULL_TURN;
    plus_t  = plain + FULL_TURN;
    m_plain = mag_f(plain);
    m_minus = mag_f(minus_t);
    m_plus  = mag_f(plus_t);
    priority if (m_plain < m_minus && m_plain < m_plus) begin
      err_w = plain;
    end else if (m_minus < m_plain && m_minus < m_plus) begin
      err_w = minus_t;
    end else begin
      err_w = plus_t;
    end
    m_err = mag_f(err_w);

    sum_base  = start0_q ? '0 : sum_q;
    prev_base = start0_q ? '0 : prev_err_q;

    sum_add = (SumW+1)'(sum_base) + (SumW+1)'(err_w);
    if (gain_i_q != '0 && m_err < {{(WideW-HeadW){1'b0}}, zone_q}) begin
      if (sum_add[SumW] != sum_add[SumW-1]) begin
        // saturate at the signed limits
        sum_d = sum_add[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
        sum_d = sum_add[SumW-1:0];
      end
    end else begin
      sum_d = '0;
    end

    deriv_d = DerivW'(err_w - prev_base);
    done_d  = m_err <= {{(WideW-HeadW){1'b0}}, thresh_q};
  end

  // gain products
  logic signed [GainW:0] gp_s, gi_s, gd_s;
  assign gp_s = $signed({1'b0, gain_p_q});
  assign gi_s = $signed({1'b0, gain_i_q});
  assign gd_s = $signed({1'b0, gain_d_q});

  // sum, floor shift, clamp, zero drive when the turn is done
  logic signed [AccW-1:0]  acc;
  logic signed [ShW-1:0]   pow_sh, lim;
  logic signed [OutW-1:0]  pow_d;

  always_comb begin
    acc    = AccW'(p_prod_q) + AccW'(i_prod_q) + AccW'(d_prod_q);
    pow_sh = acc[AccW-1:GAIN_FRAC_BITS];
    lim    = $signed({{(ShW-PowerW){1'b0}}, max_power_q});
    priority if (done2_q) begin
      pow_d = '0;
    end else if (pow_sh > lim) begin
      pow_d = OutW'(lim);
    end else if (pow_sh < -lim) begin
      pow_d = OutW'(-lim);
    end else begin
      pow_d = pow_sh[OutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      prev_err_q  <= '0;
      sum_q       <= '0;
    end else if (adv) begin
      v0_q        <= in_valid_i;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
      if (v0_q) begin
        prev_err_q <= err_w;
        sum_q      <= sum_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      meas0_q   <= measured_heading_i;
      start0_q  <= start_req_i;
      err1_q    <= err_w;
      sum1_q    <= sum_d;
      deriv1_q  <= deriv_d;
      done1_q   <= done_d;
      err2_q    <= err1_q[ErrW-1:0];
      done2_q   <= done1_q;
      p_prod_q  <= gp_s * err1_q;
      i_prod_q  <= gi_s * sum1_q;
      d_prod_q  <= gd_s * deriv1_q;
      left_q    <= pow_d;
      err_out_q <= err2_q;
      done_q    <= done2_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_power_o    = left_q;
  assign right_power_o   = -left_q;
  assign heading_error_o = err_out_q;
  assign done_res_o      = done_q;

  // a finished turn never drives the motors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (left_power_o == '0))
    else $error("done result with nonzero drive");

  // a stalled result holds until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(left_power_o)
      && $stable(heading_error_o) && $stable(done_res_o)))
    else $error("stalled result changed");

  // zero integral gain clears the integral
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v0_q && gain_i_q == '0) |=> (sum_q == '0))
    else $error("integral not cleared with zero gain");

  // the drive never reaches the negative code that has no positive twin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_power_o != {1'b1, {(OutW-1){1'b0}}}))
    else $error("drive value out of range");

endmodule

FILE: bench/turn_check_pkg.sv
`timescale 1ns / 100ps
// turn_check_pkg: expected-result record and scoreboard class for the heading pid
// turn controller bench. Depends on hpid_pkg for widths, register codes and the turn.
package turn_check_pkg;
  import hpid_pkg::*;

  localparam longint SumHi = 64'sd2147483647;
  localparam longint SumLo = -64'sd2147483648;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic signed [OutW-1:0] left;
    logic signed [OutW-1:0] right;
    logic signed [ErrW-1:0] err;
    logic                   done;
  } drive_result_t;

  class turn_step_scoreboard;
    logic [HeadW-1:0]  target_heading;
    logic [PowerW-1:0] max_power;
    logic [HeadW-1:0]  stop_threshold;
    logic [GainW-1:0]  gain_p;
    logic [GainW-1:0]  gain_i;
    logic [GainW-1:0]  gain_d;
    logic [HeadW-1:0]  integral_zone;
    // loop state kept at full width, the tie case can push the error past 14 bits
    int                last_error;
    int                error_sum;
    drive_result_t     expected_drive_q[$];
    int unsigned       n_samples;
    int unsigned       n_checked;
    int unsigned       n_stopped;
    int unsigned       n_mismatch;

    function new();
      target_heading = '0;
      max_power      = PowerW'(127);
      stop_threshold = HeadW'(16);
      gain_p         = GainW'(256);
      gain_i         = '0;
      gain_d         = '0;
      integral_zone  = '0;
      last_error     = 0;
      error_sum      = 0;
      n_samples      = 0;
      n_checked      = 0;
      n_stopped      = 0;
      n_mismatch     = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_TARGET_HEADING: target_heading = data[HeadW-1:0];
        REG_MAX_POWER:      max_power      = data[PowerW-1:0];
        REG_STOP_THRESHOLD: stop_threshold = data[HeadW-1:0];
        REG_GAIN_P:         gain_p         = data[GainW-1:0];
        REG_GAIN_I:         gain_i         = data[GainW-1:0];
        REG_GAIN_D:         gain_d         = data[GainW-1:0];
        REG_INTEGRAL_ZONE:  integral_zone  = data[HeadW-1:0];
        default: ;
      endcase
    endfunction

    static function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // one pid step for an accepted sample, result goes to the back of the queue
    function void note_sample(logic [HeadW-1:0] heading, logic start);
      longint        plain;
      longint        minus_turn;
      longint        plus_turn;
      longint        err;
      longint        deriv;
      longint        acc;
      longint        power;
      longint        neg_power;
      longint        lim;
      longint        sum;
      drive_result_t want;
      if (start) begin
        last_error = 0;
        error_sum  = 0;
      end
      plain      = longint'(target_heading) - longint'(heading);
      minus_turn = plain - longint'(FULL_TURN);
      plus_turn  = plain + longint'(FULL_TURN);
      if (magnitude(plain) < magnitude(minus_turn) && magnitude(plain) < magnitude(plus_turn))
        err = plain;
      else if (magnitude(minus_turn) < magnitude(plain)
               && magnitude(minus_turn) < magnitude(plus_turn))
        err = minus_turn;
      else
        err = plus_turn;  // ties land here
      if (gain_i != 0 && magnitude(err) < longint'(integral_zone)) begin
        sum = longint'(error_sum) + err;
        if (sum > SumHi) sum = SumHi;
        if (sum < SumLo) sum = SumLo;
        error_sum = int'(sum);
      end else begin
        error_sum = 0;
      end
      deriv      = err - longint'(last_error);
      last_error = int'(err);
      acc = longint'(gain_p) * err + longint'(gain_i) * longint'(error_sum)
          + longint'(gain_d) * deriv;
      power = acc >>> GAIN_FRAC_BITS;
      lim   = longint'(max_power);
      if (power > lim) power = lim;
      if (power < -lim) power = -lim;
      want.done = magnitude(err) <= longint'(stop_threshold);
      if (want.done) begin
        power = 0;
        n_stopped++;
      end
      neg_power  = -power;
      want.left  = power[OutW-1:0];
      want.right = neg_power[OutW-1:0];
      want.err   = err[ErrW-1:0];
      expected_drive_q.push_back(want);
      n_samples++;
    endfunction

    function void check_drive(drive_result_t got);
      drive_result_t want;
      if (expected_drive_q.size() == 0) begin
        if (n_mismatch < ReportLimit)
          $display("unexpected result: left %0d right %0d error %0d done %0b",
                   got.left, got.right, got.err, got.done);
        n_mismatch++;
        return;
      end
      want = expected_drive_q.pop_front();
      if (got.left !== want.left || got.right !== want.right
          || got.err !== want.err || got.done !== want.done) begin
        if (n_mismatch < ReportLimit)
          $display("mismatch on result %0d: left %0d/%0d right %0d/%0d error %0d/%0d done %0b/%0b (exp/act)",
                   n_checked, want.left, got.left, want.right, got.right,
                   want.err, got.err, want.done, got.done);
        n_mismatch++;
      end
      n_checked++;
    endfunction

    function int pending();
      return expected_drive_q.size();
    endfunction
  endclass

endpackage

FILE: bench/tb_heading_pid_turn_controller_top.sv
`timescale 1ns / 100ps
// tb_heading_pid_turn_controller_top: directed and random heading samples against
// a scoreboard model. Depends on hpid_pkg, turn_check_pkg and the controller rtl.
module tb_heading_pid_turn_controller_top;
  import hpid_pkg::*;
  import turn_check_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;

  localparam int unsigned RandPhases    = 8;
  localparam int unsigned PhaseSamples  = 216;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles  = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [HeadW-1:0]      measured_heading_i = '0;
  logic                  start_req_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [OutW-1:0] left_power_o;
  logic signed [OutW-1:0] right_power_o;
  logic signed [ErrW-1:0] heading_error_o;
  logic                  done_res_o;

  turn_step_scoreboard turn_sb;
  idle_mode_e          src_mode = IDLE_NONE;
  idle_mode_e          sink_mode = IDLE_NONE;
  int                  sink_hold = 0;
  int                  quiet_cycles = 0;

  heading_pid_turn_controller_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .measured_heading_i (measured_heading_i),
    .start_req_i        (start_req_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .left_power_o       (left_power_o),
    .right_power_o      (right_power_o),
    .heading_error_o    (heading_error_o),
    .done_res_o         (done_res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int pick_gap(input idle_mode_e mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == IDLE_NONE) return 0;
    if (r < ((mode == IDLE_LIGHT) ? 70 : 35)) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // consumer side: ready high for a cycle, then maybe held low for a while
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      out_ready_i <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      sink_hold = pick_gap(sink_mode);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        turn_sb.check_drive(drive_result_t'{left_power_o, right_power_o,
                                            heading_error_o, done_res_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("no transaction for %0d cycles, %0d results still expected",
                 quiet_cycles, turn_sb.pending());
        $display("heading_pid_turn_controller_top verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    turn_sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sometimes zero or the field maximum at the extremes, mostly a typical value;
  // bits above the field width are random
  task automatic write_random_reg(input cfg_reg_e idx, input int unsigned mask,
                                  input int unsigned typ_hi);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 99);
    if (r < 10) v = 0;
    else if (r < 20) v = mask;
    else v = $urandom_range(0, typ_hi);
    write_reg(idx, CfgDataW'(($urandom & ~mask) | v));
  endtask

  task automatic send_heading(input logic [HeadW-1:0] heading, input logic start);
    int gap;
    gap = pick_gap(src_mode);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i         <= 1'b1;
    measured_heading_i <= heading;
    start_req_i        <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    turn_sb.note_sample(heading, start);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (turn_sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int                walk;
    int                delta;
    int                tgt;
    int                r;
    logic [HeadW-1:0]  heading;
    logic              start;
    turn_sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // settings after reset: exact stop edge, wrap onto the plus turn, the tie at half a turn
    src_mode  = IDLE_LIGHT;
    sink_mode = IDLE_LIGHT;
    send_heading(13'd0, 1'b1);
    send_heading(13'd16, 1'b0);
    send_heading(13'd17, 1'b0);
    send_heading(13'd5759, 1'b0);
    send_heading(13'd2880, 1'b0);
    send_heading(13'd2881, 1'b0);
    send_heading(13'd2879, 1'b0);
    send_heading(13'd8191, 1'b0);
    send_heading(13'd5760, 1'b0);
    send_heading(13'd4000, 1'b1);
    drain();

    // full gains, zero threshold, widest zone; upper data bits must be dropped
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_TARGET_HEADING, 16'hEB40);
    write_reg(REG_MAX_POWER, 16'hFFFF);
    write_reg(REG_STOP_THRESHOLD, 16'h0000);
    write_reg(REG_GAIN_P, 16'hFFFF);
    write_reg(REG_GAIN_I, 16'hFFFF);
    write_reg(REG_GAIN_D, 16'hFFFF);
    write_reg(REG_INTEGRAL_ZONE, 16'hFFFF);
    send_heading(13'd0, 1'b1);
    send_heading(13'd2880, 1'b0);
    send_heading(13'd2879, 1'b0);
    send_heading(13'd2881, 1'b0);
    send_heading(13'd8191, 1'b0);
    send_heading(13'd5759, 1'b0);
    send_heading(13'd100, 1'b1);
    drain();

    // zero drive limit, widest threshold, integral gain with a closed zone
    write_reg(REG_MAX_POWER, 16'h0000);
    write_reg(REG_STOP_THRESHOLD, 16'h1FFF);
    write_reg(REG_GAIN_P, 16'h0001);
    write_reg(REG_GAIN_I, 16'h0001);
    write_reg(REG_GAIN_D, 16'h0000);
    write_reg(REG_INTEGRAL_ZONE, 16'h0000);
    send_heading(13'd0, 1'b1);
    send_heading(13'd1000, 1'b0);
    send_heading(13'd5000, 1'b0);
    drain();

    // highest target, small gain so negative sums show the floor on the shift
    write_reg(REG_TARGET_HEADING, 16'h1FFF);
    write_reg(REG_MAX_POWER, 16'd64);
    write_reg(REG_STOP_THRESHOLD, 16'd0);
    write_reg(REG_GAIN_P, 16'd3);
    write_reg(REG_GAIN_I, 16'd0);
    write_reg(REG_GAIN_D, 16'd256);
    write_reg(REG_INTEGRAL_ZONE, 16'd100);
    send_heading(13'd0, 1'b1);
    send_heading(13'd8191, 1'b0);
    send_heading(13'd2432, 1'b0);
    send_heading(13'd8000, 1'b0);
    drain();

    walk = 0;
    for (int ph = 0; ph < RandPhases; ph++) begin
      write_random_reg(REG_TARGET_HEADING, 32'h1FFF, 5759);
      write_random_reg(REG_MAX_POWER, 32'h7F, 127);
      write_random_reg(REG_STOP_THRESHOLD, 32'h1FFF, 64);
      write_random_reg(REG_GAIN_P, 32'hFFFF, 1024);
      write_random_reg(REG_GAIN_I, 32'hFFFF, 64);
      write_random_reg(REG_GAIN_D, 32'hFFFF, 1024);
      write_random_reg(REG_INTEGRAL_ZONE, 32'h1FFF, 400);
      write_reg(REG_UNUSED, CfgDataW'($urandom));
      src_mode  = idle_mode_e'($urandom_range(0, 2));
      sink_mode = idle_mode_e'($urandom_range(0, 2));
      tgt = int'(turn_sb.target_heading);
      for (int i = 0; i < PhaseSamples; i++) begin
        r = $urandom_range(0, 99);
        start = 1'b0;
        if (r < 6) begin
          // a fresh turn from anywhere on the circle
          walk  = $urandom_range(0, 5759);
          start = 1'b1;
          heading = HeadW'(walk);
        end else if (r < 80) begin
          // close in on the target with some sensor noise
          delta = tgt - walk;
          if (delta > 2880) delta -= 5760;
          if (delta < -2880) delta += 5760;
          walk = walk + delta / int'($urandom_range(2, 6))
               + int'($urandom_range(0, 16)) - 8;
          walk = ((walk % 5760) + 5760) % 5760;
          heading = HeadW'(walk);
        end else if (r < 83) begin
          // exactly half a turn away
          heading = (tgt >= 2880) ? HeadW'(tgt - 2880) : HeadW'(tgt + 2880);
        end else if (r < 93) begin
          heading = HeadW'($urandom_range(0, 5759));
          start   = ($urandom_range(0, 9) == 0);
        end else begin
          heading = HeadW'($urandom_range(0, 8191));
          start   = ($urandom_range(0, 9) == 0);
        end
        send_heading(heading, start);
      end
      drain();
    end

    repeat (SettleCycles) @(posedge clk_i);
    $display("%0d heading samples over %0d register settings, %0d results checked",
             turn_sb.n_samples, RandPhases + 4, turn_sb.n_checked);
    $display("%0d steps inside the stop threshold, %0d mismatches",
             turn_sb.n_stopped, turn_sb.n_mismatch);
    if (turn_sb.n_mismatch == 0 && turn_sb.pending() == 0) begin
      $display("heading_pid_turn_controller_top verification clean");
    end else begin
      $display("heading_pid_turn_controller_top verification failed");
    end
    $finish;
  end

endmodule
